### hw/rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by the top level and its port checker.
package rgbhsv_pkg;

  // One input beat: an 8-bit RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One result beat: hue in fixed-point degrees, saturation, value.
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_t;

  localparam int HUE_W = 15;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEPS_PER_STAGE = 4;

  // Sector of the largest channel.
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  localparam int DEG_60  = 60;
  localparam int DEG_120 = 120;
  localparam int DEG_240 = 240;
  localparam int DEG_360 = 360;
  localparam int SAT_SCALE = 255;

endpackage

### hw/rtl/rgb_to_hsv_converter_top.sv
// RGB to HSV converter top level: sector select, numerator build and
// two pipelined restoring dividers. Depends on rgbhsv_pkg.

// The converter takes one pixel beat in every clock cycle and never pushes
// back: busy is tied low, so a beat is taken whenever start is high. Each
// result appears on result for exactly one cycle with done high, after its
// pixel has passed the stage A and stage B registers and the divider stages.
// QW = clog2(360 * 2^F) is the hue quotient width (F = HUE_FRAC_BITS). The
// hue divider resolves four quotient bits per pipeline stage; the saturation
// divider runs alongside in the same
// stages. The receiver cannot stall: it must take every done beat as it comes.
// Grey pixels give hue 0 and saturation 0; brightness is the largest channel.
module rgb_to_hsv_converter_top #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  rgbhsv_pkg::pixel_t    pixel,
  output logic                  done,
  output rgbhsv_pkg::hsv_t      result
);
  import rgbhsv_pkg::*;

  // Hue quotient width, numerator width and divider depth.
  localparam int QW  = $clog2(DEG_360 * (1 << HUE_FRAC_BITS));
  localparam int NW  = QW + 8;
  localparam int SPS = DIV_STEPS_PER_STAGE;
  localparam int NST = (QW + SPS - 1) / SPS;
  localparam int QXW = (QW > HUE_W) ? QW : HUE_W;

  // The pipeline always has room.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage A: find the largest channel, its sector, delta and difference.
  // Tie rules follow the comparison order below.
  // ---------------------------------------------------------------------
  logic              a_valid;
  logic [7:0]        a_vmax;
  logic [7:0]        a_delta;
  logic signed [8:0] a_diff;
  logic [1:0]        a_sect;
  logic              a_grey;

  logic [7:0]        sa_vmax;
  logic [7:0]        sa_vmin;
  logic signed [8:0] sa_diff;
  logic [1:0]        sa_sect;

  always_comb begin
    logic signed [8:0] r9;
    logic signed [8:0] g9;
    logic signed [8:0] b9;
    r9 = $signed({1'b0, pixel.red});
    g9 = $signed({1'b0, pixel.green});
    b9 = $signed({1'b0, pixel.blue});
    if (pixel.green > pixel.red) begin
      if (pixel.blue > pixel.green) begin
        sa_vmax = pixel.blue;
        sa_vmin = pixel.red;
        sa_sect = SECT_BLUE;
        sa_diff = r9 - g9;
      end else begin
        sa_vmax = pixel.green;
        sa_vmin = (pixel.blue < pixel.red) ? pixel.blue : pixel.red;
        sa_sect = SECT_GREEN;
        sa_diff = b9 - r9;
      end
    end else begin
      if (pixel.red > pixel.blue) begin
        sa_vmax = pixel.red;
        sa_vmin = (pixel.green < pixel.blue) ? pixel.green : pixel.blue;
        sa_sect = SECT_RED;
        sa_diff = g9 - b9;
      end else begin
        sa_vmax = pixel.blue;
        sa_vmin = pixel.green;
        sa_sect = SECT_BLUE;
        sa_diff = r9 - g9;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_vmax  <= sa_vmax;
    a_delta <= sa_vmax - sa_vmin;
    a_diff  <= sa_diff;
    a_sect  <= sa_sect;
    a_grey  <= (pixel.red == pixel.green) && (pixel.green == pixel.blue);
  end

  // ---------------------------------------------------------------------
  // Stage B: build the hue numerator (offset*delta + 60*diff, wrapped by
  // 360*delta when negative, scaled by 2^F) and the saturation numerator.
  // Grey pixels get divisor 1 so both quotients come out zero.
  // ---------------------------------------------------------------------
  logic              dv   [0:NST];
  logic [7:0]        hrem [0:NST];
  logic [QW-1:0]     hacc [0:NST];
  logic [7:0]        hden [0:NST];
  logic [7:0]        srem [0:NST];
  logic [7:0]        sacc [0:NST];
  logic [7:0]        sden [0:NST];
  logic [7:0]        bval [0:NST];

  logic [16:0]        b_off;
  logic signed [15:0] b_diff60;
  logic signed [18:0] b_base;
  logic [16:0]        b_wrap;
  logic [NW-1:0]      b_hnum;
  logic [15:0]        b_snum;

  always_comb begin
    unique case (a_sect)
      SECT_GREEN: b_off = 17'(DEG_120) * {9'b0, a_delta};
      SECT_BLUE:  b_off = 17'(DEG_240) * {9'b0, a_delta};
      default:    b_off = '0;
    endcase
    b_diff60 = 16'(DEG_60) * {{7{a_diff[8]}}, a_diff};
    b_wrap   = 17'(DEG_360) * {9'b0, a_delta};
    b_base   = $signed({2'b0, b_off}) + $signed({{3{b_diff60[15]}}, b_diff60});
    // Red sector with blue above green: wrap into [0, 360).
    if (b_base[18]) begin
      b_base = b_base + $signed({2'b0, b_wrap});
    end
    b_hnum = NW'(b_base[16:0]) << HUE_FRAC_BITS;
    b_snum = 16'(SAT_SCALE) * {8'b0, a_delta};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= a_valid;
    end
    hrem[0] <= b_hnum[NW-1:QW];
    hacc[0] <= b_hnum[QW-1:0];
    hden[0] <= a_grey ? 8'd1 : a_delta;
    srem[0] <= b_snum[15:8];
    sacc[0] <= b_snum[7:0];
    sden[0] <= a_grey ? 8'd1 : a_vmax;
    bval[0] <= a_vmax;
  end

  // ---------------------------------------------------------------------
  // Divider stages: restoring division, SPS quotient bits per stage.
  // The accumulator shifts the numerator out at the top and the quotient
  // in at the bottom; the remainder always stays below the divisor.
  // Saturation needs only the first eight steps.
  // ---------------------------------------------------------------------
  for (genvar gs = 0; gs < NST; gs++) begin : g_div
    logic [7:0]    nx_hrem;
    logic [QW-1:0] nx_hacc;
    logic [7:0]    nx_srem;
    logic [7:0]    nx_sacc;

    always_comb begin
      logic [8:0] t;
      nx_hrem = hrem[gs];
      nx_hacc = hacc[gs];
      nx_srem = srem[gs];
      nx_sacc = sacc[gs];
      for (int j = 0; j < SPS; j++) begin
        if (gs * SPS + j < QW) begin
          t       = {nx_hrem, nx_hacc[QW-1]};
          nx_hacc = nx_hacc << 1;
          if (t >= {1'b0, hden[gs]}) begin
            t          = t - {1'b0, hden[gs]};
            nx_hacc[0] = 1'b1;
          end
          nx_hrem = t[7:0];
        end
        if (gs * SPS + j < 8) begin
          t       = {nx_srem, nx_sacc[7]};
          nx_sacc = nx_sacc << 1;
          if (t >= {1'b0, sden[gs]}) begin
            t          = t - {1'b0, sden[gs]};
            nx_sacc[0] = 1'b1;
          end
          nx_srem = t[7:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[gs+1] <= 1'b0;
      end else begin
        dv[gs+1] <= dv[gs];
      end
      hrem[gs+1] <= nx_hrem;
      hacc[gs+1] <= nx_hacc;
      hden[gs+1] <= hden[gs];
      srem[gs+1] <= nx_srem;
      sacc[gs+1] <= nx_sacc;
      sden[gs+1] <= sden[gs];
      bval[gs+1] <= bval[gs];
    end
  end

  // ---------------------------------------------------------------------
  // Output: the last divider stage drives the result beat directly.
  // Hue keeps its low 15 bits when the fraction is wider than default.
  // ---------------------------------------------------------------------
  logic [QXW-1:0] hue_ext;

  assign hue_ext           = QXW'(hacc[NST]);
  assign done              = dv[NST];
  assign result.hue        = hue_ext[HUE_W-1:0];
  assign result.saturation = sacc[NST];
  assign result.brightness = bval[NST];

endmodule

### hw/rtl/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV converter, with its bind.
// Depends on rgbhsv_pkg and the ports of rgb_to_hsv_converter_top.
module rgbhsv_checker #(
  parameter int HUE_FRAC_BITS = 6
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input rgbhsv_pkg::hsv_t   result
);
  import rgbhsv_pkg::*;

  localparam int QW  = $clog2(DEG_360 * (1 << HUE_FRAC_BITS));
  localparam int LAT = 2 + (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  // Every accepted beat comes out after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted pixel produced no result");

  // No result without a beat accepted the fixed latency earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT) && !$past(busy, LAT) && !$past(rst, LAT))
    else $error("result without matching pixel");

  // Zero saturation means a grey pixel, whose hue must be zero.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    done && (result.saturation == 8'd0) |-> (result.hue == '0))
    else $error("grey pixel with non-zero hue");

  // Black has no colour at all.
  a_black: assert property (@(posedge clk) disable iff (rst)
    done && (result.brightness == 8'd0) |->
      (result.saturation == 8'd0) && (result.hue == '0))
    else $error("black pixel with colour");

  // The pipeline never pushes back.
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule

bind rgb_to_hsv_converter_top rgbhsv_checker #(
  .HUE_FRAC_BITS(HUE_FRAC_BITS)
) u_rgbhsv_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
